// ===== design/assert_macros.svh =====
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define FBLA_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: implication");

// Next-cycle implication, switched off while reset is high.
`define FBLA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/fbla_pkg.sv =====
`default_nettype none

package fbla_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int TimeBitsDefault   = 32;
   localparam int NumBands          = 4;
   localparam int HystBits          = 15;
   localparam int DelayBits         = 16;
   localparam int FlagsBits         = 8;
   localparam int CsrAddrBits       = 5;
   localparam int CsrDataBits       = 32;
   localparam int RspDataBits       = 16;

   localparam logic CmdEvaluate    = 1'b0;
   localparam logic CmdAcknowledge = 1'b1;

   localparam logic [2:0] RegLoloLimit  = 3'd0;
   localparam logic [2:0] RegLoLimit    = 3'd1;
   localparam logic [2:0] RegHiLimit    = 3'd2;
   localparam logic [2:0] RegHihiLimit  = 3'd3;
   localparam logic [2:0] RegHysteresis = 3'd4;
   localparam logic [2:0] RegOnDelay    = 3'd5;
   localparam logic [2:0] RegOffDelay   = 3'd6;
   localparam logic [2:0] RegBandFlags  = 3'd7;

   localparam logic [1:0] SevNone       = 2'd0;
   localparam logic [1:0] SevDiagnostic = 2'd1;
   localparam logic [1:0] SevWarning    = 2'd2;
   localparam logic [1:0] SevAlarm      = 2'd3;

   typedef struct packed {
      logic valid;
      logic ack_cmd;
      logic may_trip;
      logic faulted;
   } fbla_ctl_type;

   typedef struct packed {
      logic [NumBands-1:0] active;
      logic [NumBands-1:0] latched;
      logic [NumBands-1:0] acked;
   } fbla_masks_type;

   typedef struct packed {
      logic [HystBits-1:0]  hysteresis;
      logic [DelayBits-1:0] on_delay;
      logic [DelayBits-1:0] off_delay;
      logic [FlagsBits-1:0] band_flags;
   } fbla_shared_cfg_type;

   typedef struct packed {
      logic [HystBits-1:0]  hysteresis;
      logic [DelayBits-1:0] on_delay;
      logic [DelayBits-1:0] off_delay;
      logic                 enable;
      logic                 latching;
   } fbla_band_cfg_type;

endpackage

`default_nettype wire

// ===== design/four_band_limit_alarm_core.sv =====
// Channel   Ports          Direction  Contents
// request   req_t*         in         tdata: sample, timestamp, armed, faulted; tuser: command
// response  rsp_t*         out        tdata: masks, warning, alarm, severity
// control   csr_p*         in/out     APB-style register port, eight registers
//
// Each transaction walks a row of four band cells, one register per cell, so its result is
// presented by the output register of the last cell; with the response side ready one
// request is taken every cycle.
// The pipeline depth is set by the number of band cells.
// Reset is synchronous and active high; it clears all band state and the CSR registers.
// A stalled response freezes the whole row, and the request side then drops tready.
`default_nettype none
`include "assert_macros.svh"

module four_band_limit_alarm_core
   import fbla_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int TIME_BITS   = TimeBitsDefault,
   localparam int ReqDataBits = ((SAMPLE_BITS + TIME_BITS + 2 + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request: tdata from bit 0 up holds sample_value, time_ms, armed, sensor_faulted,
   // then zero padding to whole bytes.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ReqDataBits-1:0] req_tdata,
   // Request: tuser holds command (evaluate or acknowledge).
   input  wire logic [0:0]             req_tuser,
   // Response: tdata from bit 0 up holds active_mask, latched_mask, acked_mask,
   // warning, alarm, severity.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RspDataBits-1:0] rsp_tdata,
   // Configuration port.
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CsrAddrBits-1:0] csr_paddr,
   input  wire logic [CsrDataBits-1:0] csr_pwdata,
   output logic      [CsrDataBits-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int TimeLsb     = SAMPLE_BITS;
   localparam int ArmedBit    = SAMPLE_BITS + TIME_BITS;
   localparam int FaultBit    = SAMPLE_BITS + TIME_BITS + 1;

   logic [SAMPLE_BITS-1:0] limit [NumBands];
   fbla_shared_cfg_type    shared_cfg;
   fbla_band_cfg_type      band_cfg [NumBands];

   // Link k feeds cell k; link NumBands is the output register of the last cell.
   fbla_ctl_type           link_ctl    [NumBands+1];
   logic [SAMPLE_BITS-1:0] link_sample [NumBands+1];
   logic [TIME_BITS-1:0]   link_time   [NumBands+1];
   fbla_masks_type         link_masks  [NumBands+1];

   logic                   advance;
   logic                   armed;
   logic                   faulted;
   fbla_masks_type         final_masks;
   logic [NumBands-1:0]    either;
   logic                   warning;
   logic                   alarm;
   logic [1:0]             severity;
   logic                   ack_out;
   logic                   ack_masks_ok;

   fbla_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limit       (limit),
      .shared_cfg  (shared_cfg)
   );

   // The row moves as one: whenever the output register is free or being emptied.
   assign advance    = !link_ctl[NumBands].valid || rsp_tready;
   assign req_tready = advance;

   assign armed   = req_tdata[ArmedBit];
   assign faulted = req_tdata[FaultBit];

   always_comb begin
      link_ctl[0].valid    = req_tvalid;
      link_ctl[0].ack_cmd  = req_tuser[0];
      link_ctl[0].may_trip = armed && !faulted;
      link_ctl[0].faulted  = faulted;
      link_sample[0]       = req_tdata[SAMPLE_BITS-1:0];
      link_time[0]         = req_tdata[TimeLsb +: TIME_BITS];
      link_masks[0]        = '0;
   end

   for (genvar b = 0; b < NumBands; b++) begin : g_band
      always_comb begin
         band_cfg[b].hysteresis = shared_cfg.hysteresis;
         band_cfg[b].on_delay   = shared_cfg.on_delay;
         band_cfg[b].off_delay  = shared_cfg.off_delay;
         band_cfg[b].enable     = shared_cfg.band_flags[b];
         band_cfg[b].latching   = shared_cfg.band_flags[b+NumBands];
      end

      // The low bands (LoLo, Lo) trip at or below their limit, the high ones at or above.
      fbla_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .TIME_BITS   (TIME_BITS),
         .BAND        (b),
         .HIGH_SIDE   (b >= 2)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cfg        (band_cfg[b]),
         .limit      (limit[b]),
         .in_ctl     (link_ctl[b]),
         .in_sample  (link_sample[b]),
         .in_time    (link_time[b]),
         .in_masks   (link_masks[b]),
         .out_ctl    (link_ctl[b+1]),
         .out_sample (link_sample[b+1]),
         .out_time   (link_time[b+1]),
         .out_masks  (link_masks[b+1])
      );
   end

   // Roll-ups are formed from the final masks, which already reflect every band's update.
   assign final_masks = link_masks[NumBands];
   assign either      = final_masks.active | final_masks.latched;
   assign warning     = either[1] || either[2];
   assign alarm       = either[0] || either[3];

   always_comb begin
      if (alarm) begin
         severity = SevAlarm;
      end else if (warning) begin
         severity = SevWarning;
      end else if (link_ctl[NumBands].faulted) begin
         severity = SevDiagnostic;
      end else begin
         severity = SevNone;
      end
   end

   assign rsp_tvalid = link_ctl[NumBands].valid;
   assign rsp_tdata  = {severity, alarm, warning,
                        final_masks.acked, final_masks.latched, final_masks.active};

   assign ack_out      = rsp_tvalid && (link_ctl[NumBands].ack_cmd == CmdAcknowledge);
   assign ack_masks_ok = ((final_masks.latched & ~final_masks.active) == '0) &&
                         ((final_masks.latched & ~final_masks.acked) == '0);

   // After an acknowledge, every remaining latch belongs to an active, acknowledged band.
   `FBLA_ASSERT_IMPLIES(a_ack_result, clock, reset, ack_out, ack_masks_ok)

   // A held row never loses a transaction from any of its stages.
   for (genvar k = 1; k <= NumBands; k++) begin : g_hold_check
      `FBLA_ASSERT_NEXT(a_stage_holds, clock, reset, link_ctl[k].valid && !advance, link_ctl[k].valid)
   end

endmodule

`default_nettype wire

// ===== design/fbla_csr.sv =====
`default_nettype none

module fbla_csr
   import fbla_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CsrAddrBits-1:0] csr_paddr,
   input  wire logic [CsrDataBits-1:0] csr_pwdata,
   output logic      [CsrDataBits-1:0] csr_prdata,
   output logic                        csr_pready,
   output logic      [SAMPLE_BITS-1:0] limit [NumBands],
   output fbla_shared_cfg_type         shared_cfg
);

   logic [SAMPLE_BITS-1:0] limit_ff [NumBands];
   fbla_shared_cfg_type    cfg_ff;
   logic [2:0]             index;
   logic                   write_strobe;

   assign csr_pready   = 1'b1;
   assign index        = csr_paddr[4:2];
   assign write_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumBands; i++) begin
            limit_ff[i] <= '0;
         end
         cfg_ff <= '0;
      end else if (write_strobe) begin
         unique case (index)
            RegLoloLimit:  limit_ff[0] <= csr_pwdata[SAMPLE_BITS-1:0];
            RegLoLimit:    limit_ff[1] <= csr_pwdata[SAMPLE_BITS-1:0];
            RegHiLimit:    limit_ff[2] <= csr_pwdata[SAMPLE_BITS-1:0];
            RegHihiLimit:  limit_ff[3] <= csr_pwdata[SAMPLE_BITS-1:0];
            RegHysteresis: cfg_ff.hysteresis <= csr_pwdata[HystBits-1:0];
            RegOnDelay:    cfg_ff.on_delay   <= csr_pwdata[DelayBits-1:0];
            RegOffDelay:   cfg_ff.off_delay  <= csr_pwdata[DelayBits-1:0];
            RegBandFlags:  cfg_ff.band_flags <= csr_pwdata[FlagsBits-1:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         RegLoloLimit:  csr_prdata = CsrDataBits'(limit_ff[0]);
         RegLoLimit:    csr_prdata = CsrDataBits'(limit_ff[1]);
         RegHiLimit:    csr_prdata = CsrDataBits'(limit_ff[2]);
         RegHihiLimit:  csr_prdata = CsrDataBits'(limit_ff[3]);
         RegHysteresis: csr_prdata = CsrDataBits'(cfg_ff.hysteresis);
         RegOnDelay:    csr_prdata = CsrDataBits'(cfg_ff.on_delay);
         RegOffDelay:   csr_prdata = CsrDataBits'(cfg_ff.off_delay);
         RegBandFlags:  csr_prdata = CsrDataBits'(cfg_ff.band_flags);
         default:       csr_prdata = '0;
      endcase
   end

   assign limit      = limit_ff;
   assign shared_cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/fbla_cell.sv =====
`default_nettype none

module fbla_cell
   import fbla_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int TIME_BITS   = TimeBitsDefault,
   parameter int BAND        = 0,
   parameter bit HIGH_SIDE   = 1'b0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire fbla_band_cfg_type      cfg,
   input  wire logic [SAMPLE_BITS-1:0] limit,
   input  wire fbla_ctl_type           in_ctl,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic [TIME_BITS-1:0]   in_time,
   input  wire fbla_masks_type         in_masks,
   output fbla_ctl_type                out_ctl,
   output logic      [SAMPLE_BITS-1:0] out_sample,
   output logic      [TIME_BITS-1:0]   out_time,
   output fbla_masks_type              out_masks
);

   // Wide enough that limit plus or minus the hysteresis never wraps.
   localparam int CmpBits = ((SAMPLE_BITS > HystBits) ? SAMPLE_BITS : HystBits) + 2;

   logic                   raw_ff, raw_in;
   logic                   active_ff, active_in;
   logic                   latch_ff, latch_in;
   logic                   ack_ff, ack_in;
   logic [TIME_BITS-1:0]   change_time_ff, change_time_in;

   fbla_ctl_type           out_ctl_ff;
   logic [SAMPLE_BITS-1:0] out_sample_ff;
   logic [TIME_BITS-1:0]   out_time_ff;
   fbla_masks_type         out_masks_ff, out_masks_in;

   logic signed [CmpBits-1:0] value_ext;
   logic signed [CmpBits-1:0] limit_ext;
   logic signed [CmpBits-1:0] hyst_ext;
   logic signed [CmpBits-1:0] threshold;
   logic                      raw_now;
   logic                      changed;
   logic [TIME_BITS-1:0]      elapsed;
   logic [TIME_BITS-1:0]      on_delay_ext;
   logic [TIME_BITS-1:0]      off_delay_ext;

   assign value_ext = signed'({{(CmpBits-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample});
   assign limit_ext = signed'({{(CmpBits-SAMPLE_BITS){limit[SAMPLE_BITS-1]}}, limit});
   assign hyst_ext  = active_ff ? signed'({{(CmpBits-HystBits){1'b0}}, cfg.hysteresis})
                                : '0;

   // The clear threshold moves away from the limit while the band is active.
   assign threshold = HIGH_SIDE ? (limit_ext - hyst_ext) : (limit_ext + hyst_ext);
   assign raw_now   = HIGH_SIDE ? (value_ext >= threshold) : (value_ext <= threshold);
   assign changed   = raw_now != raw_ff;
   assign elapsed   = changed ? '0 : (in_time - change_time_ff);

   assign on_delay_ext  = {{(TIME_BITS-DelayBits){1'b0}}, cfg.on_delay};
   assign off_delay_ext = {{(TIME_BITS-DelayBits){1'b0}}, cfg.off_delay};

   always_comb begin
      raw_in         = raw_ff;
      active_in      = active_ff;
      latch_in       = latch_ff;
      ack_in         = ack_ff;
      change_time_in = change_time_ff;
      if (in_ctl.valid && advance) begin
         if (in_ctl.ack_cmd == CmdEvaluate) begin
            if (!cfg.enable) begin
               raw_in    = 1'b0;
               active_in = 1'b0;
               latch_in  = 1'b0;
            end else begin
               raw_in = raw_now;
               if (changed) begin
                  change_time_in = in_time;
               end
               if (raw_now && !active_ff) begin
                  if (in_ctl.may_trip && (elapsed >= on_delay_ext)) begin
                     active_in = 1'b1;
                     if (cfg.latching) begin
                        latch_in = 1'b1;
                        ack_in   = 1'b0;
                     end
                  end
               end else if (!raw_now && active_ff) begin
                  if (elapsed >= off_delay_ext) begin
                     active_in = 1'b0;
                  end
               end
            end
         end else begin
            ack_in   = ack_ff | latch_ff;
            latch_in = latch_ff & active_ff;
         end
      end
   end

   always_comb begin
      out_masks_in               = in_masks;
      out_masks_in.active[BAND]  = active_in;
      out_masks_in.latched[BAND] = latch_in;
      out_masks_in.acked[BAND]   = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff         <= 1'b0;
         active_ff      <= 1'b0;
         latch_ff       <= 1'b0;
         ack_ff         <= 1'b0;
         change_time_ff <= '0;
         out_ctl_ff     <= '0;
      end else begin
         raw_ff         <= raw_in;
         active_ff      <= active_in;
         latch_ff       <= latch_in;
         ack_ff         <= ack_in;
         change_time_ff <= change_time_in;
         if (advance) begin
            out_ctl_ff <= in_ctl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= in_sample;
         out_time_ff   <= in_time;
         out_masks_ff  <= out_masks_in;
      end
   end

   assign out_ctl    = out_ctl_ff;
   assign out_sample = out_sample_ff;
   assign out_time   = out_time_ff;
   assign out_masks  = out_masks_ff;

endmodule

`default_nettype wire
